// File: src/hcd_pkg.sv
// ----------------------------------------------------------------------------
// hcd_pkg
// Types, constants and helpers shared by the chunked response decoder.
// ----------------------------------------------------------------------------
package hcd_pkg;

    localparam int unsigned PAT_LEN    = 26;
    localparam int unsigned QDEPTH     = 4;
    localparam int unsigned QPTR_W     = $clog2(QDEPTH);
    localparam logic [19:0] STATUS_MAX = 20'd999999;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_NO_TERM = 2'd1;
    localparam logic [1:0] ERR_STATUS  = 2'd2;

    localparam logic KIND_BODY   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef enum logic [6:0] {
        PH_HEADER = 7'b0000001,
        PH_PLAIN  = 7'b0000010,
        PH_SIZE   = 7'b0000100,
        PH_DATA   = 7'b0001000,
        PH_SKIP   = 7'b0010000,
        PH_DONE   = 7'b0100000,
        PH_REJECT = 7'b1000000
    } t_phase;

    typedef enum logic [2:0] {
        NUM_SKIPWS = 3'b001,
        NUM_DIGITS = 3'b010,
        NUM_DONE   = 3'b100
    } t_num;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_response;
    } t_in;

    typedef struct packed {
        logic        kind;
        logic [7:0]  body_byte;
        logic [19:0] resp_status;
        logic        ok;
        logic [1:0]  error_code;
        logic        body_truncated;
        logic        last;
    } t_out;

    typedef struct packed {
        logic        has_body;
        logic [7:0]  body_byte;
        logic        has_rep;
        logic [19:0] resp_status;
        logic        ok;
        logic [1:0]  error_code;
        logic        body_truncated;
    } t_cmd;

    function automatic logic [7:0] pat_char(input logic [4:0] pos);
        logic [7:0] c;
        case (pos)
            5'd0:  c = "t";
            5'd1:  c = "r";
            5'd2:  c = "a";
            5'd3:  c = "n";
            5'd4:  c = "s";
            5'd5:  c = "f";
            5'd6:  c = "e";
            5'd7:  c = "r";
            5'd8:  c = "-";
            5'd9:  c = "e";
            5'd10: c = "n";
            5'd11: c = "c";
            5'd12: c = "o";
            5'd13: c = "d";
            5'd14: c = "i";
            5'd15: c = "n";
            5'd16: c = "g";
            5'd17: c = ":";
            5'd18: c = " ";
            5'd19: c = "c";
            5'd20: c = "h";
            5'd21: c = "u";
            5'd22: c = "n";
            5'd23: c = "k";
            5'd24: c = "e";
            5'd25: c = "d";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // {valid, value}
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, b[3:0]};
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            r = {1'b1, b[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

// File: src/hcd_front.sv
// ----------------------------------------------------------------------------
// hcd_front
// Parses each accepted byte: header scan, status, chunk framing; issues commands.
// ----------------------------------------------------------------------------
module hcd_front #(
    parameter int unsigned CHUNK_SIZE_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  hcd_pkg::t_in  i_data,
    input  logic          i_accept,
    output hcd_pkg::t_cmd o_cmd,
    output logic          o_push
);
    import hcd_pkg::*;

    localparam int unsigned W = CHUNK_SIZE_BITS;

    t_phase         r_phase, n_phase;
    logic [23:0]    r_recent, n_recent;
    logic           r_line_done, n_line_done;
    logic           r_space, n_space;
    t_num           r_num, n_num;
    logic           r_neg, n_neg;
    logic [19:0]    r_status, n_status;
    logic [4:0]     r_pos, n_pos;
    logic           r_chunked, n_chunked;
    logic [W-1:0]   r_rem, n_rem;
    logic           r_digits_done, n_digits_done;
    logic [1:0]     r_skip, n_skip;

    logic [7:0]  b;
    logic [7:0]  lc;
    logic        fin;
    logic        prev_cr;
    logic        term;
    logic        is_digit;
    logic        is_ws;
    logic [23:0] stat_wide;
    logic [4:0]  hv;
    t_cmd        cmd;

    assign b        = i_data.rx_byte;
    assign fin      = i_data.end_of_response;
    assign prev_cr  = (r_recent[7:0] == CH_CR);
    assign term     = (r_recent == {CH_CR, CH_LF, CH_CR}) && (b == CH_LF);
    assign lc       = (b inside {[8'h41:8'h5A]}) ? (b + 8'd32) : b;
    assign is_digit = b inside {[8'h30:8'h39]};
    assign is_ws    = (b == CH_SPACE) || (b inside {[8'h09:8'h0D]});
    assign stat_wide = ({4'd0, r_status} << 3) + ({4'd0, r_status} << 1)
                     + {20'd0, b[3:0]};
    assign hv       = hex_val(b);

    always_comb begin
        n_phase       = r_phase;
        n_recent      = r_recent;
        n_line_done   = r_line_done;
        n_space       = r_space;
        n_num         = r_num;
        n_neg         = r_neg;
        n_status      = r_status;
        n_pos         = r_pos;
        n_chunked     = r_chunked;
        n_rem         = r_rem;
        n_digits_done = r_digits_done;
        n_skip        = r_skip;
        cmd           = '0;

        case (r_phase)
            PH_HEADER: begin
                if (!r_line_done) begin
                    if (prev_cr && b == CH_LF) begin
                        n_line_done = 1'b1;
                    end else if (!r_space) begin
                        if (b == CH_SPACE) begin
                            n_space = 1'b1;
                        end
                    end else if (r_num == NUM_SKIPWS && is_ws) begin
                        n_num = NUM_SKIPWS;
                    end else if (r_num == NUM_SKIPWS && (b == CH_PLUS || b == CH_MINUS)) begin
                        n_neg = (b == CH_MINUS);
                        n_num = NUM_DIGITS;
                    end else if (r_num != NUM_DONE && is_digit) begin
                        n_status = (stat_wide > {4'd0, STATUS_MAX}) ? STATUS_MAX
                                                                    : stat_wide[19:0];
                        n_num = NUM_DIGITS;
                    end else begin
                        n_num = NUM_DONE;
                    end
                end
                if (!r_chunked) begin
                    if (lc == pat_char(r_pos)) begin
                        n_pos = r_pos + 5'd1;
                        if (r_pos == 5'(PAT_LEN - 1)) begin
                            n_chunked = 1'b1;
                        end
                    end else begin
                        n_pos = (lc == pat_char(5'd0)) ? 5'd1 : 5'd0;
                    end
                end
                n_recent = {r_recent[15:0], b};
                if (term) begin
                    if (n_neg || n_status == 20'd0) begin
                        n_phase = PH_REJECT;
                    end else if (n_chunked) begin
                        n_phase       = PH_SIZE;
                        n_rem         = '0;
                        n_digits_done = 1'b0;
                        n_recent      = '0;
                    end else begin
                        n_phase = PH_PLAIN;
                    end
                end
            end
            PH_PLAIN: begin
                cmd.has_body  = 1'b1;
                cmd.body_byte = b;
            end
            PH_SIZE: begin
                if (prev_cr && b == CH_LF) begin
                    n_phase = (r_rem == '0) ? PH_DONE : PH_DATA;
                end else if (!r_digits_done && hv[4]) begin
                    if (r_rem[W-1:W-4] != 4'd0) begin
                        n_rem = '1;
                    end else begin
                        n_rem = {r_rem[W-5:0], hv[3:0]};
                    end
                end else begin
                    n_digits_done = 1'b1;
                end
                n_recent = {r_recent[15:0], b};
            end
            PH_DATA: begin
                cmd.has_body  = 1'b1;
                cmd.body_byte = b;
                n_rem = r_rem - W'(1);
                if (n_rem == '0) begin
                    n_phase = PH_SKIP;
                    n_skip  = 2'd2;
                end
            end
            PH_SKIP: begin
                if (r_skip != 2'd0) begin
                    n_skip = r_skip - 2'd1;
                end
                if (n_skip == 2'd0) begin
                    n_phase       = PH_SIZE;
                    n_rem         = '0;
                    n_digits_done = 1'b0;
                    n_recent      = '0;
                end
            end
            default: begin
            end
        endcase

        if (fin) begin
            cmd.has_rep = 1'b1;
            if (n_phase == PH_HEADER) begin
                cmd.error_code = ERR_NO_TERM;
            end else if (n_phase == PH_REJECT) begin
                cmd.error_code = ERR_STATUS;
            end else begin
                cmd.error_code     = ERR_NONE;
                cmd.ok             = 1'b1;
                cmd.resp_status    = n_status;
                cmd.body_truncated = (n_phase == PH_DATA) && (n_rem != '0);
            end
            n_phase       = PH_HEADER;
            n_recent      = '0;
            n_line_done   = 1'b0;
            n_space       = 1'b0;
            n_num         = NUM_SKIPWS;
            n_neg         = 1'b0;
            n_status      = '0;
            n_pos         = '0;
            n_chunked     = 1'b0;
            n_rem         = '0;
            n_digits_done = 1'b0;
            n_skip        = '0;
        end
    end

    assign o_cmd  = cmd;
    assign o_push = i_accept && (cmd.has_body || cmd.has_rep);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HEADER;
            r_recent      <= '0;
            r_line_done   <= 1'b0;
            r_space       <= 1'b0;
            r_num         <= NUM_SKIPWS;
            r_neg         <= 1'b0;
            r_status      <= '0;
            r_pos         <= '0;
            r_chunked     <= 1'b0;
            r_rem         <= '0;
            r_digits_done <= 1'b0;
            r_skip        <= '0;
        end else if (i_accept) begin
            r_phase       <= n_phase;
            r_recent      <= n_recent;
            r_line_done   <= n_line_done;
            r_space       <= n_space;
            r_num         <= n_num;
            r_neg         <= n_neg;
            r_status      <= n_status;
            r_pos         <= n_pos;
            r_chunked     <= n_chunked;
            r_rem         <= n_rem;
            r_digits_done <= n_digits_done;
            r_skip        <= n_skip;
        end
    end

endmodule

// File: src/hcd_queue.sv
// ----------------------------------------------------------------------------
// hcd_queue
// Short command queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module hcd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hcd_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output hcd_pkg::t_cmd o_head,
    output logic          o_empty,
    output logic          o_full
);
    import hcd_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QPTR_W:0]   r_count;

    assign o_head  = r_mem[r_rptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (QPTR_W + 1)'(QDEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: src/hcd_back.sv
// ----------------------------------------------------------------------------
// hcd_back
// Turns queued commands into result transactions: body byte first, then report.
// ----------------------------------------------------------------------------
module hcd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  hcd_pkg::t_cmd i_head,
    input  logic          i_empty,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output hcd_pkg::t_out o_out_data,
    output logic          o_pop
);
    import hcd_pkg::*;

    logic r_body_sent;
    logic send_body;
    logic xfer;
    t_out res;

    assign send_body   = i_head.has_body && !r_body_sent;
    assign o_out_valid = !i_empty;
    assign xfer        = o_out_valid && i_out_ready;
    assign o_pop       = xfer && !(send_body && i_head.has_rep);

    always_comb begin
        res = '0;
        if (send_body) begin
            res.kind      = KIND_BODY;
            res.body_byte = i_head.body_byte;
        end else begin
            res.kind           = KIND_REPORT;
            res.resp_status    = i_head.resp_status;
            res.ok             = i_head.ok;
            res.error_code     = i_head.error_code;
            res.body_truncated = i_head.body_truncated;
            res.last           = 1'b1;
        end
    end

    assign o_out_data = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_body_sent <= 1'b0;
        end else if (o_pop) begin
            r_body_sent <= 1'b0;
        end else if (xfer) begin
            r_body_sent <= 1'b1;
        end
    end

endmodule

// File: src/http_response_chunked_decoder.sv
// ----------------------------------------------------------------------------
// http_response_chunked_decoder
// HTTP/1.1 response byte parser with chunked body decoding and final report.
// ----------------------------------------------------------------------------
//  channel  direction  payload  handshake
//  input    in         t_in     i_in_valid / o_in_ready
//  output   out        t_out    o_out_valid / i_out_ready
//
//  One byte is parsed per cycle on acceptance; results go through a
//  four-entry command queue, so input keeps flowing while output stalls.
//  A byte that yields both a body byte and the report gives two output
//  transactions; input stalls only when the queue is full.
//  Reset is synchronous, active low; parser returns to the header phase.
// ----------------------------------------------------------------------------
module http_response_chunked_decoder #(
    parameter int unsigned CHUNK_SIZE_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  hcd_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output hcd_pkg::t_out o_out_data
);
    import hcd_pkg::*;

    t_cmd cmd;
    t_cmd head;
    logic push;
    logic pop;
    logic empty;
    logic full;
    logic accept;

    assign o_in_ready = !full;
    assign accept     = i_in_valid && o_in_ready;

    hcd_front #(
        .CHUNK_SIZE_BITS(CHUNK_SIZE_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_data   (i_in_data),
        .i_accept (accept),
        .o_cmd    (cmd),
        .o_push   (push)
    );

    hcd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    hcd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_empty     (empty),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .o_pop       (pop)
    );

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the chunked response decoder: directed responses,
// a stall run, then random plain, chunked, malformed responses, idle or not.
// ----------------------------------------------------------------------------
module tb;
    import hcd_pkg::*;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_in_valid = 1'b0;
    logic  o_in_ready;
    t_in   i_in_data = '0;
    logic  o_out_valid;
    logic  i_out_ready = 1'b0;
    t_out  o_out_data;

    http_response_chunked_decoder DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );

    always #5 i_clk = ~i_clk;

    typedef enum int {S_HEAD, S_PLAIN, S_SIZE, S_DATA, S_SKIP, S_DONE, S_REJECT} t_sp;
    localparam string PATTERN = "transfer-encoding: chunked";

    t_out expected_q[$];
    int   errors = 0;
    int   sent_bytes = 0;
    int   got_results = 0;
    int   responses = 0;
    int   stall_hold = 0;
    int   stall_reqs = 0;
    int   stall_taken = 0;
    bit   sender_gaps = 1'b1;
    bit   recv_gaps = 1'b1;

    // decoder shadow state
    t_sp         sp;
    logic [23:0] last3;
    bit          line1_done, space_hit, neg;
    t_num        num_step;
    logic [19:0] status;
    int          pat_pos;
    bit          is_chunked;
    logic [31:0] remain;
    bit          digits_end;
    int          skip_left;

    function automatic void clear_decoder();
        sp = S_HEAD; last3 = '0; line1_done = 0; space_hit = 0; neg = 0;
        num_step = NUM_SKIPWS; status = '0; pat_pos = 0; is_chunked = 0; remain = '0;
        digits_end = 0; skip_left = 0;
    endfunction

    function automatic void add_expected(logic k, logic [7:0] b, logic [19:0] st,
                                         logic ok, logic [1:0] err, logic tr, logic l);
        t_out r;
        r.kind = k; r.body_byte = b; r.resp_status = st; r.ok = ok;
        r.error_code = err; r.body_truncated = tr; r.last = l;
        expected_q = {expected_q, r};
    endfunction

    function automatic void take_status_char(logic [7:0] b);
        logic [23:0] v;
        if (num_step == NUM_SKIPWS) begin
            if (b == 8'h20 || (b >= 8'h09 && b <= 8'h0D)) return;
            if (b == CH_PLUS || b == CH_MINUS) begin
                neg = (b == CH_MINUS);
                num_step = NUM_DIGITS;
                return;
            end
        end
        if (num_step != NUM_DONE && b >= "0" && b <= "9") begin
            v = 24'(status * 10 + (b - "0"));
            status = (v > STATUS_MAX) ? STATUS_MAX : v[19:0];
            num_step = NUM_DIGITS;
            return;
        end
        num_step = NUM_DONE;
    endfunction

    function automatic int hexdig(logic [7:0] b);
        if (b >= "0" && b <= "9") return int'(b - "0");
        if (b >= "a" && b <= "f") return int'(b - "a") + 10;
        if (b >= "A" && b <= "F") return int'(b - "A") + 10;
        return -1;
    endfunction

    function automatic void decode_byte(logic [7:0] b, bit fin);
        bit prev_cr, term;
        logic [7:0] lc;
        int h;
        prev_cr = (last3[7:0] == CH_CR);
        case (sp)
            S_HEAD: begin
                term = (last3 == 24'h0D0A0D) && b == CH_LF;
                if (!line1_done) begin
                    if (prev_cr && b == CH_LF) line1_done = 1;
                    else if (!space_hit) begin
                        if (b == CH_SPACE) space_hit = 1;
                    end else take_status_char(b);
                end
                if (!is_chunked) begin
                    lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
                    if (lc == PATTERN[pat_pos]) begin
                        pat_pos++;
                        if (pat_pos >= PAT_LEN) is_chunked = 1;
                    end else pat_pos = (lc == PATTERN[0]) ? 1 : 0;
                end
                last3 = {last3[15:0], b};
                if (term) begin
                    if (neg || status == 0) sp = S_REJECT;
                    else if (is_chunked) begin
                        sp = S_SIZE; remain = '0; digits_end = 0; last3 = '0;
                    end else sp = S_PLAIN;
                end
            end
            S_PLAIN: add_expected(KIND_BODY, b, '0, 1'b0, ERR_NONE, 1'b0, 1'b0);
            S_SIZE: begin
                if (prev_cr && b == CH_LF) sp = (remain == 0) ? S_DONE : S_DATA;
                else begin
                    h = hexdig(b);
                    if (!digits_end && h >= 0) begin
                        if (remain > 32'h0FFFFFFF) remain = '1;
                        else remain = {remain[27:0], h[3:0]};
                    end else digits_end = 1;
                end
                last3 = {last3[15:0], b};
            end
            S_DATA: begin
                add_expected(KIND_BODY, b, '0, 1'b0, ERR_NONE, 1'b0, 1'b0);
                remain--;
                if (remain == 0) begin sp = S_SKIP; skip_left = 2; end
            end
            S_SKIP: begin
                if (skip_left > 0) skip_left--;
                if (skip_left == 0) begin
                    sp = S_SIZE; remain = '0; digits_end = 0; last3 = '0;
                end
            end
            default: ;
        endcase
        if (fin) begin
            if (sp == S_HEAD)
                add_expected(KIND_REPORT, 8'h00, '0, 1'b0, ERR_NO_TERM, 1'b0, 1'b1);
            else if (sp == S_REJECT)
                add_expected(KIND_REPORT, 8'h00, '0, 1'b0, ERR_STATUS, 1'b0, 1'b1);
            else add_expected(KIND_REPORT, 8'h00, status, 1'b1, ERR_NONE,
                              (sp == S_DATA && remain > 0), 1'b1);
            clear_decoder();
        end
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_byte(logic [7:0] b, bit fin);
        int g;
        g = sender_gaps ? gap_len() : 0;
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{rx_byte: b, end_of_response: fin};
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        decode_byte(b, fin);
        sent_bytes++;
        if (fin) responses++;
        @(negedge i_clk);
    endtask

    task automatic send_text(string s, bit fin_at_end);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], fin_at_end && i == s.len() - 1);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // receiver ready
    always @(negedge i_clk) begin
        if (stall_taken != stall_reqs) begin
            stall_taken <= stall_reqs;
            stall_hold <= 200;
            i_out_ready <= 1'b0;
        end else if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
            i_out_ready <= 1'b0;
        end else if (recv_gaps) begin
            i_out_ready <= ($urandom_range(0, 99) < 70) ? 1'b1 :
                           ($urandom_range(0, 9) == 0 ? 1'b0 : 1'b0);
            if ($urandom_range(0, 199) == 0) stall_hold <= $urandom_range(10, 40);
        end else i_out_ready <= 1'b1;
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got_results++;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected transaction, actual %p", $time, o_out_data);
            end else begin
                if (o_out_data !== expected_q[0]) begin
                    errors++;
                    $display("%0t: mismatch, expected %p, actual %p",
                             $time, expected_q[0], o_out_data);
                end
                void'(expected_q.pop_front());
            end
        end
    end

    function automatic string rand_header_noise(int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(32, 126)))};
        return s;
    endfunction

    function automatic string mixed_case(string s);
        string r;
        r = s;
        for (int i = 0; i < r.len(); i++)
            if (r[i] >= "a" && r[i] <= "z" && $urandom_range(0, 1)) r[i] = r[i] - 8'd32;
        return r;
    endfunction

    task automatic test_directed();
        send_text("HTTP/1.1 200 OK\r\nContent-Length: 3\r\n\r\nab\xff", 1);
        send_text("HTTP/1.1 +404 X\r\nTRANSFER-ENCODING: Chunked\r\n\r\n", 0);
        send_text("3;ext=1\r\n\x01\x80z\r\nA\r\n0123456789\r\n0\r\ntrailer\r\n\r\n", 1);
        send_text("HTTP/1.1 9999999\r\n\r\nq", 1);
        send_text("HTTP/1.1 -5\r\n\r\nbody", 1);
        send_text("HTTP/1.1 0\r\n\r\n", 1);
        send_text("NOSPACE\r\n\r\nx", 1);
        send_text("HTTP/1.1 200\r\nno terminator", 1);
        send_text("HTTP/1.1 \t 201\r\ntransfer-encoding: chunked\r\n\r\nfffffffff\r\nab", 1);
        send_text("HTTP/1.1 202\r\ntransfer-encoding: chunked\r\n\r\nzz\r\nx", 1);
        send_text("HTTP/1.1 203\r\ntransfer-encoding: chunked\r\n\r\n2\r\nab\r", 1);
        drain();
    endtask

    task automatic send_random_response();
        int kind, nchunks, len;
        string h;
        kind = $urandom_range(0, 99);
        h = $sformatf("HTTP/1.1 %0d R\r\n", $urandom_range(100, 599));
        if (kind < 10) h = $sformatf("HTTP/1.1 %s\r\n", rand_header_noise($urandom_range(0, 6)));
        if (kind >= 55) h = {h, mixed_case("transfer-encoding: chunked"), "\r\n"};
        else if (kind >= 45) h = {h, "transfer-encodin: chunke", "\r\n"};
        h = {h, "X-", rand_header_noise($urandom_range(0, 8)), "\r\n\r\n"};
        if (kind < 5) begin
            send_text(rand_header_noise($urandom_range(1, 20)), 1);
            return;
        end
        send_text(h, 0);
        if (kind < 55) begin
            len = $urandom_range(0, 12);
            for (int i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)), 0);
            send_byte(8'($urandom_range(0, 255)), 1);
            return;
        end
        nchunks = $urandom_range(0, 3);
        for (int c = 0; c < nchunks; c++) begin
            len = $urandom_range(1, 9);
            send_text($sformatf((c % 2) ? "%0x;e\r\n" : "%0X\r\n", len), 0);
            if ($urandom_range(0, 19) == 0) begin
                for (int i = 0; i < len - 1; i++) send_byte(8'($urandom_range(0, 255)), 0);
                send_byte(8'($urandom_range(0, 255)), 1);
                return;
            end
            for (int i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)), 0);
            send_byte(8'($urandom_range(0, 255)), 0);
            send_byte(8'($urandom_range(0, 255)), 0);
        end
        send_text("0\r\n", 0);
        send_byte(8'($urandom_range(0, 255)), 1);
    endtask

    task automatic test_random();
        while (sent_bytes < 1950) send_random_response();
        drain();
    endtask

    task automatic test_backpressure();
        sender_gaps = 1'b0;
        stall_reqs++;
        send_text("HTTP/1.1 200 OK\r\n\r\n", 0);
        for (int i = 0; i < 40; i++) send_byte(8'($urandom_range(0, 255)), i == 39);
        sender_gaps = 1'b1;
        drain();
    endtask

    task automatic test_no_gaps();
        sender_gaps = 1'b0;
        recv_gaps = 1'b0;
        for (int i = 0; i < 6; i++) send_random_response();
        sender_gaps = 1'b1;
        recv_gaps = 1'b1;
        drain();
    endtask

    initial begin
        clear_decoder();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_backpressure();
        test_no_gaps();
        test_random();
        $display("tb: %0d bytes in %0d responses, %0d results checked",
                 sent_bytes, responses, got_results);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: %0d errors, %0d results missing", errors, expected_q.size());
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end
endmodule
